### rtl/gwws_pkg.sv
`timescale 1ns / 1ps

package gwws_pkg;

   // default sizes
   localparam int WORD_BUFFER_BYTES_DEF = 62;
   localparam int MAX_WIDTH_DEF         = 63;

   // fixed field widths
   localparam int WIDTH_W = 6;   // wrap width register
   localparam int CNT_W   = 6;   // word byte / code point counts
   localparam int LINE_W  = 7;   // columns on the current line

   // byte codes
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] UTF_MASK    = 8'hC0;
   localparam logic [7:0] UTF_CONT    = 8'h80;

   // input kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [1:0] {
      SEP_NONE,
      SEP_SPACE,
      SEP_NL
   } sep_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_BYTE,
      TAIL_END
   } tail_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SEP,
      BK_RD,
      BK_WR,
      BK_TAIL
   } back_state_type;

   // one emit job handed from front to back
   typedef struct packed {
      sep_type          sep;
      logic [CNT_W-1:0] len;
      logic             bank;
      tail_type         tail;
      logic [7:0]       tail_byte;
      logic             forced;
   } cmd_type;

   // word buffer bank released by the back end
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   // one result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
      logic       forced_break;
   } rsp_type;

   function automatic logic is_gap(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
             (b == CH_VT) || (b == CH_FF);
   endfunction

endpackage

### rtl/gwws_ram.sv
`timescale 1ns / 1ps

module gwws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gwws_fifo.sv
`timescale 1ns / 1ps

module gwws_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/gwws_front.sv
`timescale 1ns / 1ps

module gwws_front #(
   parameter int WORD_BUFFER_BYTES = gwws_pkg::WORD_BUFFER_BYTES_DEF,
   parameter int MAX_WIDTH         = gwws_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [gwws_pkg::WIDTH_W-1:0]          wrap_width,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  kind,
   input  logic [7:0]                            text_byte,
   output logic                                  cmd_push,
   output gwws_pkg::cmd_type                     cmd,
   input  logic                                  cmd_full,
   input  gwws_pkg::rel_type                     rel,
   output logic                                  wr_en,
   output logic [$clog2(WORD_BUFFER_BYTES):0]    wr_addr,
   output logic [7:0]                            wr_data
);

   localparam int AW = $clog2(WORD_BUFFER_BYTES);
   localparam int CW = gwws_pkg::CNT_W;
   localparam int LW = gwws_pkg::LINE_W;

   logic [LW-1:0] line_chars_ff, line_chars_in;
   logic          line_has_word_ff, line_has_word_in;
   logic [CW-1:0] pend_bytes_ff, pend_bytes_in;
   logic [CW-1:0] pend_chars_ff, pend_chars_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;

   logic [gwws_pkg::WIDTH_W-1:0] width;
   logic [LW:0]                  fit_sum;
   gwws_pkg::sep_type            pl_sep;
   logic [LW-1:0]                pl_line;
   logic                         has_word;
   logic                         store_full;
   logic                         accept;
   logic                         is_lead;
   logic                         set_busy;

   // widths above the limit act as the limit
   assign width = (wrap_width > gwws_pkg::WIDTH_W'(MAX_WIDTH)) ?
                  gwws_pkg::WIDTH_W'(MAX_WIDTH) : wrap_width;

   assign has_word   = (pend_bytes_ff != '0);
   assign store_full = (pend_bytes_ff == CW'(WORD_BUFFER_BYTES));
   assign is_lead    = ((text_byte & gwws_pkg::UTF_MASK) != gwws_pkg::UTF_CONT);

   // a bank still being read back blocks new writes into it
   assign full   = cmd_full || busy_ff[bank_ff] || (store_full && busy_ff[!bank_ff]);
   assign accept = push && !full;

   // separator choice for placing the held word
   assign fit_sum = (LW+1)'(line_chars_ff) + (LW+1)'(1) + (LW+1)'(pend_chars_ff);
   always_comb begin
      if (line_has_word_ff) begin
         if (fit_sum <= (LW+1)'(width)) begin
            pl_sep  = gwws_pkg::SEP_SPACE;
            pl_line = fit_sum[LW-1:0];
         end else begin
            pl_sep  = gwws_pkg::SEP_NL;
            pl_line = LW'(pend_chars_ff);
         end
      end else begin
         pl_sep  = gwws_pkg::SEP_NONE;
         pl_line = LW'(pend_chars_ff);
      end
   end

   always_comb begin
      line_chars_in    = line_chars_ff;
      line_has_word_in = line_has_word_ff;
      pend_bytes_in    = pend_bytes_ff;
      pend_chars_in    = pend_chars_ff;
      bank_in          = bank_ff;
      set_busy         = 1'b0;
      cmd_push         = 1'b0;
      cmd.sep          = has_word ? pl_sep : gwws_pkg::SEP_NONE;
      cmd.len          = pend_bytes_ff;
      cmd.bank         = bank_ff;
      cmd.tail         = gwws_pkg::TAIL_NONE;
      cmd.tail_byte    = text_byte;
      cmd.forced       = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = {bank_ff, pend_bytes_ff[AW-1:0]};
      wr_data          = text_byte;

      if (accept) begin
         priority if (width == '0) begin
            // pass-through: held word goes out raw
            cmd_push         = 1'b1;
            cmd.sep          = gwws_pkg::SEP_NONE;
            cmd.tail         = (kind == gwws_pkg::KIND_END) ?
                               gwws_pkg::TAIL_END : gwws_pkg::TAIL_BYTE;
            set_busy         = has_word;
            pend_bytes_in    = '0;
            pend_chars_in    = '0;
            line_chars_in    = '0;
            line_has_word_in = 1'b0;
         end else if (kind == gwws_pkg::KIND_END || text_byte == gwws_pkg::CH_NL) begin
            cmd_push         = 1'b1;
            cmd.tail         = (kind == gwws_pkg::KIND_END) ?
                               gwws_pkg::TAIL_END : gwws_pkg::TAIL_BYTE;
            set_busy         = has_word;
            pend_bytes_in    = '0;
            pend_chars_in    = '0;
            line_chars_in    = '0;
            line_has_word_in = 1'b0;
         end else if (gwws_pkg::is_gap(text_byte)) begin
            if (has_word) begin
               cmd_push         = 1'b1;
               set_busy         = 1'b1;
               pend_bytes_in    = '0;
               pend_chars_in    = '0;
               line_chars_in    = pl_line;
               line_has_word_in = 1'b1;
            end
         end else if (store_full) begin
            // word store full: place what is held, new byte opens the next word
            cmd_push         = 1'b1;
            cmd.forced       = 1'b1;
            set_busy         = 1'b1;
            line_chars_in    = pl_line;
            line_has_word_in = 1'b1;
            wr_en            = 1'b1;
            wr_addr          = {!bank_ff, AW'(0)};
            pend_bytes_in    = CW'(1);
            pend_chars_in    = CW'(is_lead);
         end else begin
            wr_en         = 1'b1;
            pend_bytes_in = pend_bytes_ff + 1'b1;
            pend_chars_in = pend_chars_ff + CW'(is_lead);
         end
         if (set_busy) begin
            bank_in = !bank_ff;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (set_busy) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_chars_ff    <= '0;
         line_has_word_ff <= 1'b0;
         pend_bytes_ff    <= '0;
         pend_chars_ff    <= '0;
         bank_ff          <= 1'b0;
         busy_ff          <= '0;
      end else begin
         line_chars_ff    <= line_chars_in;
         line_has_word_ff <= line_has_word_in;
         pend_bytes_ff    <= pend_bytes_in;
         pend_chars_ff    <= pend_chars_in;
         bank_ff          <= bank_in;
         busy_ff          <= busy_in;
      end
   end

endmodule

### rtl/gwws_back.sv
`timescale 1ns / 1ps

module gwws_back #(
   parameter int WORD_BUFFER_BYTES = gwws_pkg::WORD_BUFFER_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_empty,
   input  gwws_pkg::cmd_type                  cmd_rd,
   output logic                               cmd_pop,
   output gwws_pkg::rel_type                  rel,
   output logic                               rd_en,
   output logic [$clog2(WORD_BUFFER_BYTES):0] rd_addr,
   input  logic [7:0]                         rd_data,
   output logic                               out_push,
   output gwws_pkg::rsp_type                  out_data,
   input  logic                               out_full
);

   localparam int AW = $clog2(WORD_BUFFER_BYTES);
   localparam int CW = gwws_pkg::CNT_W;

   gwws_pkg::back_state_type state_ff, state_in;
   gwws_pkg::cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     last_byte;

   assign last_byte = ((idx_ff + 1'b1) == cmd_ff.len);
   assign rd_addr   = {cmd_ff.bank, idx_ff[AW-1:0]};

   always_comb begin
      state_in              = state_ff;
      cmd_in                = cmd_ff;
      idx_in                = idx_ff;
      cmd_pop               = 1'b0;
      rel.valid             = 1'b0;
      rel.bank              = cmd_ff.bank;
      rd_en                 = 1'b0;
      out_push              = 1'b0;
      out_data.out_byte     = rd_data;
      out_data.has_byte     = 1'b1;
      out_data.last         = 1'b0;
      out_data.forced_break = cmd_ff.forced;

      unique case (state_ff)
         gwws_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_rd;
               idx_in  = '0;
               priority if (cmd_rd.sep != gwws_pkg::SEP_NONE) begin
                  state_in = gwws_pkg::BK_SEP;
               end else if (cmd_rd.len != '0) begin
                  state_in = gwws_pkg::BK_RD;
               end else if (cmd_rd.tail != gwws_pkg::TAIL_NONE) begin
                  state_in = gwws_pkg::BK_TAIL;
               end else begin
                  state_in = gwws_pkg::BK_IDLE;
               end
            end
         end
         gwws_pkg::BK_SEP: begin
            out_data.out_byte = (cmd_ff.sep == gwws_pkg::SEP_SPACE) ?
                                gwws_pkg::CH_SPACE : gwws_pkg::CH_NL;
            if (!out_full) begin
               out_push = 1'b1;
               state_in = gwws_pkg::BK_RD;
            end
         end
         gwws_pkg::BK_RD: begin
            rd_en    = 1'b1;
            state_in = gwws_pkg::BK_WR;
         end
         gwws_pkg::BK_WR: begin
            out_data.last = last_byte && (cmd_ff.tail == gwws_pkg::TAIL_NONE);
            if (!out_full) begin
               out_push = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (last_byte) begin
                  rel.valid = 1'b1;
                  state_in  = (cmd_ff.tail != gwws_pkg::TAIL_NONE) ?
                              gwws_pkg::BK_TAIL : gwws_pkg::BK_IDLE;
               end else begin
                  state_in = gwws_pkg::BK_RD;
               end
            end
         end
         gwws_pkg::BK_TAIL: begin
            out_data.last = 1'b1;
            if (cmd_ff.tail == gwws_pkg::TAIL_END) begin
               out_data.out_byte = 8'h00;
               out_data.has_byte = 1'b0;
            end else begin
               out_data.out_byte = cmd_ff.tail_byte;
            end
            if (!out_full) begin
               out_push = 1'b1;
               state_in = gwws_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = gwws_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwws_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

endmodule

### rtl/greedy_word_wrap_stream.sv
`timescale 1ns / 1ps

// Greedy word wrap on a UTF-8 byte stream. Each input word is a text byte or an end-of-text
// mark; results are the wrapped bytes, with last set on the final result caused by one input
// and an end marker (has_byte low) closing each text. A front end takes one input per cycle
// while full is low, tracks the line and the word being gathered, and stores word bytes into
// one of two banks of a word buffer RAM. When a word is complete it queues a short emit job;
// the back end then takes the job, plays out the separator, reads each buffered byte from the
// RAM and then outputs it, and plays out any trailing byte (a newline, or the raw byte in
// pass-through) or end marker, taking no new job before that. Input stalls (full high) when
// the job queue is full or when the next word would go into a bank whose previous word is
// still being read out.
// wrap_width may only be changed while the block is idle.

module greedy_word_wrap_stream #(
   parameter int WORD_BUFFER_BYTES = gwws_pkg::WORD_BUFFER_BYTES_DEF,
   parameter int MAX_WIDTH         = gwws_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // input words
   input  logic                         push,
   output logic                         full,
   input  logic                         req_kind,
   input  logic [7:0]                   req_text_byte,
   // result words
   output logic                         empty,
   input  logic                         pop,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_has_byte,
   output logic                         rsp_last,
   output logic                         rsp_forced_break,
   // wrap width register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gwws_pkg::WIDTH_W-1:0] csr_wrap_width
);

   localparam int RAM_AW    = $clog2(WORD_BUFFER_BYTES) + 1;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   logic [gwws_pkg::WIDTH_W-1:0] wrap_width_ff, wrap_width_in;

   gwws_pkg::cmd_type cmd_wr, cmd_rd;
   logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
   gwws_pkg::rel_type rel;

   logic              ram_wr_en, ram_rd_en;
   logic [RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   gwws_pkg::rsp_type out_wr, out_rd;
   logic              out_push, out_full;

   // config register, always ready
   assign csr_ready     = 1'b1;
   assign wrap_width_in = (csr_valid && csr_ready) ? csr_wrap_width : wrap_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= '0;
      end else begin
         wrap_width_ff <= wrap_width_in;
      end
   end

   // classify input, track line state, fill word buffer
   gwws_front #(
      .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES),
      .MAX_WIDTH         (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .wrap_width (wrap_width_ff),
      .push       (push),
      .full       (full),
      .kind       (req_kind),
      .text_byte  (req_text_byte),
      .cmd_push   (cmd_push),
      .cmd        (cmd_wr),
      .cmd_full   (cmd_full),
      .rel        (rel),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data)
   );

   // emit jobs between front and back
   gwws_fifo #(
      .WIDTH ($bits(gwws_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   // two-bank word buffer
   gwws_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // play out separator, word bytes and tail
   gwws_back #(
      .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_rd    (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rel       (rel),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data   (ram_rd_data),
      .out_push  (out_push),
      .out_data  (out_wr),
      .out_full  (out_full)
   );

   // result queue decouples the back end from the consumer
   gwws_fifo #(
      .WIDTH ($bits(gwws_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd),
      .empty   (empty)
   );

   assign rsp_out_byte     = out_rd.out_byte;
   assign rsp_has_byte     = out_rd.has_byte;
   assign rsp_last         = out_rd.last;
   assign rsp_forced_break = out_rd.forced_break;

endmodule

### tb/greedy_word_wrap_stream_check.sv
`timescale 1ns / 1ps

module greedy_word_wrap_stream_check #(
   parameter int WORD_BUFFER_BYTES = gwws_pkg::WORD_BUFFER_BYTES_DEF,
   parameter int MAX_WIDTH         = gwws_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         full,
   input  logic                         req_kind,
   input  logic [7:0]                   req_text_byte,
   input  logic                         empty,
   input  logic                         pop,
   input  logic [7:0]                   rsp_out_byte,
   input  logic                         rsp_has_byte,
   input  logic                         rsp_last,
   input  logic                         rsp_forced_break,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [gwws_pkg::WIDTH_W-1:0] csr_wrap_width,
   output int                           fail_count,
   output int                           words_waiting,
   output int                           words_checked,
   output int                           forced_checked
);
   import gwws_pkg::*;

   logic [WIDTH_W-1:0] width_reg;
   logic [LINE_W-1:0]  line_cols;
   logic               line_used;
   logic [CNT_W-1:0]   token_cols;
   logic [CNT_W-1:0]   token_len;
   logic [7:0]         token_buf [WORD_BUFFER_BYTES];
   rsp_type            wrapped_q [$];
   rsp_type            step_q [$];
   int                 fails = 0;
   int                 checked = 0;
   int                 forced_cnt = 0;

   function automatic void emit_word(input logic [7:0] b, input logic has);
      rsp_type r;
      r.out_byte     = b;
      r.has_byte     = has;
      r.last         = 1'b0;
      r.forced_break = 1'b0;
      step_q.insert(step_q.size(), r);
   endfunction

   function automatic void emit_token_bytes();
      for (int i = 0; i < int'(token_len); i++)
         emit_word(token_buf[i], 1'b1);
   endfunction

   function automatic void drop_token();
      token_len  = '0;
      token_cols = '0;
   endfunction

   // a held token joins the line after one space if it fits, else after a newline
   function automatic void place_token(input int cols_max);
      if (token_len == 0)
         return;
      if (line_used) begin
         if (int'(line_cols) + 1 + int'(token_cols) <= cols_max) begin
            emit_word(CH_SPACE, 1'b1);
            line_cols = LINE_W'(int'(line_cols) + 1 + int'(token_cols));
         end else begin
            emit_word(CH_NL, 1'b1);
            line_cols = LINE_W'(token_cols);
         end
      end else begin
         line_cols = LINE_W'(token_cols);
         line_used = 1'b1;
      end
      emit_token_bytes();
      drop_token();
   endfunction

   function automatic void predict_wrap(input logic kind, input logic [7:0] b);
      int   cols_max;
      logic forced;
      cols_max = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
      forced   = 1'b0;
      step_q.delete();
      if (cols_max == 0) begin
         // pass-through, a token left from a wrapped setting goes out raw first
         emit_token_bytes();
         drop_token();
         line_cols = '0;
         line_used = 1'b0;
         if (kind == KIND_END)
            emit_word(8'h00, 1'b0);
         else
            emit_word(b, 1'b1);
      end else if (kind == KIND_END) begin
         place_token(cols_max);
         emit_word(8'h00, 1'b0);
         line_cols = '0;
         line_used = 1'b0;
      end else if (b == CH_NL) begin
         place_token(cols_max);
         emit_word(CH_NL, 1'b1);
         line_cols = '0;
         line_used = 1'b0;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT ||
                   b == CH_FF) begin
         place_token(cols_max);
      end else begin
         if (token_len >= WORD_BUFFER_BYTES) begin
            place_token(cols_max);
            forced = 1'b1;
         end
         if (token_len < WORD_BUFFER_BYTES) begin
            token_buf[token_len] = b;
            token_len = token_len + 1'b1;
            if ((b & UTF_MASK) != UTF_CONT)
               token_cols = token_cols + 1'b1;
         end
      end
      foreach (step_q[k])
         step_q[k].forced_break = forced;
      if (step_q.size() > 0)
         step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[k])
         wrapped_q.insert(wrapped_q.size(), step_q[k]);
   endfunction

   // fields in messages: byte, has_byte, last, forced_break
   function automatic void check_result_word();
      rsp_type want;
      logic    bad;
      if (wrapped_q.size() == 0) begin
         fails++;
         $display("%0t: extra result, expected none, got %02h %0b %0b %0b",
                  $time, rsp_out_byte, rsp_has_byte, rsp_last, rsp_forced_break);
         return;
      end
      want = wrapped_q.pop_front();
      checked++;
      if (rsp_forced_break)
         forced_cnt++;
      bad = (rsp_out_byte != want.out_byte) || (rsp_has_byte != want.has_byte) ||
            (rsp_last != want.last) || (rsp_forced_break != want.forced_break);
      if (bad) begin
         fails++;
         $display("%0t: result mismatch, expected %02h %0b %0b %0b, got %02h %0b %0b %0b",
                  $time, want.out_byte, want.has_byte, want.last, want.forced_break,
                  rsp_out_byte, rsp_has_byte, rsp_last, rsp_forced_break);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg = '0;
         line_cols = '0;
         line_used = 1'b0;
         drop_token();
         wrapped_q.delete();
      end else begin
         // a result on the ports now was predicted by an earlier input word
         if (pop && !empty)
            check_result_word();
         if (csr_valid && csr_ready)
            width_reg = csr_wrap_width;
         if (push && !full)
            predict_wrap(req_kind, req_text_byte);
      end
      fail_count     <= fails;
      words_waiting  <= wrapped_q.size();
      words_checked  <= checked;
      forced_checked <= forced_cnt;
   end

endmodule

### tb/greedy_word_wrap_stream_test.sv
`timescale 1ns / 1ps

module greedy_word_wrap_stream_test;
   import gwws_pkg::*;

   // long enough for a full 62 byte token to play out, plus margin
   localparam int SETTLE_CYCLES = 150;
   // long enough for the block to fill up and push back on the sender
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 8;
   localparam int PHASES        = 9;

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   logic               full;
   logic               req_kind;
   logic [7:0]         req_text_byte;
   logic               empty;
   logic               pop;
   logic [7:0]         rsp_out_byte;
   logic               rsp_has_byte;
   logic               rsp_last;
   logic               rsp_forced_break;
   logic               csr_valid;
   logic               csr_ready;
   logic [WIDTH_W-1:0] csr_wrap_width;

   int fail_count;
   int words_waiting;
   int words_checked;
   int forced_checked;

   // idle odds per cycle, in percent, for each side
   int send_idle_pct = 6;
   int take_idle_pct = 53;
   // the stimulus asks for a receiver hold-off, the receiver marks it done
   int hold_asks     = 0;
   int hold_done     = 0;
   int words_sent    = 0;
   int widths_used   = 0;

   int         phase_widths [PHASES-1] = '{1, 12, 63, 0, 6, 40, 63, 1};
   logic [7:0] gap_bytes [5];

   always #1 clock = ~clock;

   greedy_word_wrap_stream dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_text_byte    (req_text_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .rsp_forced_break (rsp_forced_break),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wrap_width   (csr_wrap_width)
   );

   greedy_word_wrap_stream_check wrap_check (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_text_byte    (req_text_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .rsp_forced_break (rsp_forced_break),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wrap_width   (csr_wrap_width),
      .fail_count       (fail_count),
      .words_waiting    (words_waiting),
      .words_checked    (words_checked),
      .forced_checked   (forced_checked)
   );

   // hard limit on the whole run
   initial begin
      #1000000;
      $display("** greedy_word_wrap_stream: FAILED **");
      $finish;
   end

   // receiver: random pop, or a long hold-off when one is asked for
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_done) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = hold_asks;
         end
         pop <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // offer one input word and wait for it to be taken; each step gets at
   // most one assignment to push, so an idle cycle never glitches valid
   task automatic send_word(input logic kind, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_kind      <= kind;
      req_text_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
   endtask

   // stop sending, let every predicted result drain, then give any token
   // still in the back end time to settle before touching the register
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] w);
      csr_valid      <= 1'b1;
      csr_wrap_width <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      widths_used++;
   endtask

   // run of one to three separators, collapsed by the block
   task automatic send_gap_run();
      repeat ($urandom_range(1, 3))
         send_word(KIND_TEXT, gap_bytes[$urandom_range(4)]);
   endtask

   // one token of about len bytes: ascii, multibyte code points, and now
   // and then a stray continuation byte that adds no column
   task automatic send_token(input int len);
      int n;
      int extra;
      n = 0;
      while (n < len) begin
         if ($urandom_range(5) == 0) begin
            extra = $urandom_range(1, 3);
            send_word(KIND_TEXT, 8'($urandom_range(8'hC2, 8'hF4)));
            repeat (extra) send_word(KIND_TEXT, UTF_CONT | 8'($urandom_range(63)));
            n += 1 + extra;
         end else if ($urandom_range(30) == 0) begin
            send_word(KIND_TEXT, UTF_CONT | 8'($urandom_range(63)));
            n++;
         end else begin
            send_word(KIND_TEXT, 8'($urandom_range(8'h21, 8'h7E)));
            n++;
         end
      end
   endtask

   // well-formed text: tokens split by blanks or hard breaks, closed by an
   // end mark; a few tokens run past the word buffer to force a break
   task automatic send_random_text();
      int tokens;
      tokens = $urandom_range(1, 8);
      if ($urandom_range(7) == 0)
         send_gap_run();
      for (int t = 0; t < tokens; t++) begin
         if (t > 0) begin
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(1, 2)) send_word(KIND_TEXT, CH_NL);
            else
               send_gap_run();
         end
         if ($urandom_range(19) == 0)
            send_token($urandom_range(60, 75));
         else
            send_token($urandom_range(1, 9));
      end
      if ($urandom_range(4) == 0)
         send_gap_run();
      send_word(KIND_END, 8'($urandom));
   endtask

   // raw noise: any byte, with an odd end mark in between
   task automatic send_noise();
      repeat ($urandom_range(4, 12))
         send_word(($urandom_range(9) == 0) ? KIND_END : KIND_TEXT, 8'($urandom));
   endtask

   initial begin
      string lead_text;
      int    target;
      lead_text       = "ab c defgh";
      gap_bytes       = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
      reset          <= 1'b1;
      push           <= 1'b0;
      req_kind       <= KIND_TEXT;
      req_text_byte  <= 8'h00;
      csr_valid      <= 1'b0;
      csr_wrap_width <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // width is zero out of reset: bytes echo, end mark carries a junk byte
      send_word(KIND_TEXT, 8'h00);
      send_word(KIND_TEXT, 8'hFF);
      send_word(KIND_END, 8'hFF);
      wait_idle();

      // narrow line: token that fits after a space, one that needs a newline
      // and is longer than the line, every separator collapsed, blank line
      write_width(WIDTH_W'(4));
      for (int i = 0; i < lead_text.len(); i++)
         send_word(KIND_TEXT, lead_text[i]);
      send_word(KIND_TEXT, CH_TAB);
      send_word(KIND_TEXT, CH_CR);
      send_word(KIND_TEXT, CH_VT);
      send_word(KIND_TEXT, CH_FF);
      send_word(KIND_TEXT, CH_NL);
      send_word(KIND_TEXT, CH_NL);
      // two byte code point, then a token of a lone continuation byte
      send_word(KIND_TEXT, 8'hC3);
      send_word(KIND_TEXT, 8'hA9);
      send_word(KIND_TEXT, CH_SPACE);
      send_word(KIND_TEXT, UTF_CONT);
      send_word(KIND_END, 8'h00);
      // empty text
      send_word(KIND_END, 8'h00);
      // token left held, then width drops to zero: it leaves raw before the byte
      send_word(KIND_TEXT, "z");
      send_word(KIND_TEXT, "z");
      wait_idle();
      write_width('0);
      send_word(KIND_TEXT, 8'h7F);

      // random phases: sender idles lightly while the receiver stalls a lot,
      // then the other way round, then both run flat out
      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 53 : 0;
         take_idle_pct = (ph < 3) ? 53 : (ph < 6) ? 6 : 0;
         wait_idle();
         if (ph == PHASES - 1)
            write_width(WIDTH_W'($urandom_range(63)));
         else
            write_width(WIDTH_W'(phase_widths[ph]));
         target = words_sent + PHASE_WORDS;
         // receiver backs off while the sender keeps going
         if (ph == 1 || ph == 4) begin
            hold_asks++;
            // short words queue up jobs until the input stalls
            repeat (8) begin
               send_word(KIND_TEXT, "x");
               send_word(KIND_TEXT, CH_SPACE);
            end
         end
         while (words_sent < target) begin
            if ($urandom_range(5) == 0)
               send_noise();
            else
               send_random_text();
         end
      end
      wait_idle();

      $display("covered %0d input words over %0d width settings: directed cases,",
               words_sent, widths_used);
      $display("random text and noise; %0d result words checked, %0d from a forced break",
               words_checked, forced_checked);
      if (fail_count == 0)
         $display("** greedy_word_wrap_stream: PASSED **");
      else
         $display("** greedy_word_wrap_stream: FAILED **");
      $finish;
   end

endmodule
